// File: hdl/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// shared types, constants and the divide-by-100 helper for the hsv to rgb pipe
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

   localparam int PIPE_DEPTH = 6;

   localparam logic [8:0]  HUE_MAX    = 9'd360;
   localparam logic [6:0]  PCT_MAX    = 7'd100;
   localparam logic [7:0]  FULL_SCALE = 8'd255;
   localparam logic [8:0]  RAMP_SLOPE = 9'd425;

   // first hue of each sector after the first
   localparam logic [8:0]  SEC1_START = 9'd61;
   localparam logic [8:0]  SEC2_START = 9'd121;
   localparam logic [8:0]  SEC3_START = 9'd181;
   localparam logic [8:0]  SEC4_START = 9'd241;
   localparam logic [8:0]  SEC5_START = 9'd301;

   // ramp offsets are taken from these bases
   localparam logic [8:0]  SEC1_BASE  = 9'd60;
   localparam logic [8:0]  SEC2_BASE  = 9'd120;
   localparam logic [8:0]  SEC3_BASE  = 9'd180;
   localparam logic [8:0]  SEC4_BASE  = 9'd240;
   localparam logic [8:0]  SEC5_BASE  = 9'd300;

   // x / 100 == (x * 5243) >> 19, exact for x below 43690
   localparam logic [12:0] DIV100_MUL   = 13'd5243;
   localparam int          DIV100_SHIFT = 19;

   typedef enum logic [2:0] {
      SEC_RED_UP,
      SEC_GREEN_DOWN,
      SEC_BLUE_UP,
      SEC_GREEN_DN2,
      SEC_RED_UP2,
      SEC_BLUE_DOWN
   } sector_type;

   typedef struct packed {
      logic ld_clamp;
      logic ld_color;
   } sec_ctl_type;

   typedef struct packed {
      logic ld_lift_mul;
      logic ld_lift_add;
      logic ld_scale_mul;
      logic ld_out;
   } chan_ctl_type;

   // truncating divide by 100 for values up to 25500
   function automatic logic [7:0] div100(input logic [14:0] x);
      logic [27:0] prod;
      prod = 28'(x) * 28'(DIV100_MUL);
      return prod[DIV100_SHIFT +: 8];
   endfunction

endpackage

// File: hdl/hsvrgb_if.sv
// ----------------------------------------------------------------------------
// hsvrgb channel interfaces
// valid/ready channels for hsv request words and rgb response words
// ----------------------------------------------------------------------------
interface hsvrgb_req_if;
   logic       valid;
   logic       ready;
   logic [8:0] hue;
   logic [6:0] saturation;
   logic [6:0] brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

interface hsvrgb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: hdl/hsvrgb_sector.sv
// ----------------------------------------------------------------------------
// hsvrgb_sector
// clamps the inputs, picks the hue sector and builds the pure-hue color
// ----------------------------------------------------------------------------
module hsvrgb_sector (
   input  logic                     clock,
   input  hsvrgb_pkg::sec_ctl_type  ctl,
   input  logic [8:0]               hue,
   input  logic [6:0]               saturation,
   input  logic [6:0]               brightness,
   output logic [7:0]               red,
   output logic [7:0]               green,
   output logic [7:0]               blue,
   output logic [6:0]               inv_sat,
   output logic [6:0]               val
);

   hsvrgb_pkg::sector_type sector_ff, sector_in;
   logic [14:0] ramp_num_ff, ramp_num_in;
   logic [6:0]  inv_sat_ff, inv_sat_in;
   logic [6:0]  val_ff, val_in;

   logic [7:0]  red_ff, red_in;
   logic [7:0]  green_ff, green_in;
   logic [7:0]  blue_ff, blue_in;
   logic [6:0]  inv_sat2_ff;
   logic [6:0]  val2_ff;

   logic [8:0]  hue_c;
   logic [6:0]  sat_c;
   logic [8:0]  base;
   logic [8:0]  off_full;
   logic [5:0]  off;
   logic [7:0]  ramp;
   logic [7:0]  ramp_dn;

   // stage 1: clamp, sector, ramp numerator
   always_comb begin
      hue_c  = (hue > hsvrgb_pkg::HUE_MAX) ? hsvrgb_pkg::HUE_MAX : hue;
      sat_c  = (saturation > hsvrgb_pkg::PCT_MAX) ? hsvrgb_pkg::PCT_MAX : saturation;
      val_in = (brightness > hsvrgb_pkg::PCT_MAX) ? hsvrgb_pkg::PCT_MAX : brightness;
      inv_sat_in = hsvrgb_pkg::PCT_MAX - sat_c;
      if (hue_c < hsvrgb_pkg::SEC1_START) begin
         sector_in = hsvrgb_pkg::SEC_RED_UP;
         base      = '0;
      end else if (hue_c < hsvrgb_pkg::SEC2_START) begin
         sector_in = hsvrgb_pkg::SEC_GREEN_DOWN;
         base      = hsvrgb_pkg::SEC1_BASE;
      end else if (hue_c < hsvrgb_pkg::SEC3_START) begin
         sector_in = hsvrgb_pkg::SEC_BLUE_UP;
         base      = hsvrgb_pkg::SEC2_BASE;
      end else if (hue_c < hsvrgb_pkg::SEC4_START) begin
         sector_in = hsvrgb_pkg::SEC_GREEN_DN2;
         base      = hsvrgb_pkg::SEC3_BASE;
      end else if (hue_c < hsvrgb_pkg::SEC5_START) begin
         sector_in = hsvrgb_pkg::SEC_RED_UP2;
         base      = hsvrgb_pkg::SEC4_BASE;
      end else begin
         sector_in = hsvrgb_pkg::SEC_BLUE_DOWN;
         base      = hsvrgb_pkg::SEC5_BASE;
      end
      off_full    = hue_c - base;
      off         = off_full[5:0];
      ramp_num_in = 15'(hsvrgb_pkg::RAMP_SLOPE) * 15'(off);
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_clamp) begin
         sector_ff   <= sector_in;
         ramp_num_ff <= ramp_num_in;
         inv_sat_ff  <= inv_sat_in;
         val_ff      <= val_in;
      end
   end

   // stage 2: ramp value and channel roles
   always_comb begin
      ramp    = hsvrgb_pkg::div100(ramp_num_ff);
      ramp_dn = hsvrgb_pkg::FULL_SCALE - ramp;
      unique case (sector_ff)
         hsvrgb_pkg::SEC_RED_UP: begin
            red_in = hsvrgb_pkg::FULL_SCALE; green_in = ramp;    blue_in = '0;
         end
         hsvrgb_pkg::SEC_GREEN_DOWN: begin
            red_in = ramp_dn; green_in = hsvrgb_pkg::FULL_SCALE; blue_in = '0;
         end
         hsvrgb_pkg::SEC_BLUE_UP: begin
            red_in = '0; green_in = hsvrgb_pkg::FULL_SCALE; blue_in = ramp;
         end
         hsvrgb_pkg::SEC_GREEN_DN2: begin
            red_in = '0; green_in = ramp_dn; blue_in = hsvrgb_pkg::FULL_SCALE;
         end
         hsvrgb_pkg::SEC_RED_UP2: begin
            red_in = ramp; green_in = '0; blue_in = hsvrgb_pkg::FULL_SCALE;
         end
         hsvrgb_pkg::SEC_BLUE_DOWN: begin
            red_in = hsvrgb_pkg::FULL_SCALE; green_in = '0; blue_in = ramp_dn;
         end
         default: begin
            red_in = '0; green_in = '0; blue_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_color) begin
         red_ff      <= red_in;
         green_ff    <= green_in;
         blue_ff     <= blue_in;
         inv_sat2_ff <= inv_sat_ff;
         val2_ff     <= val_ff;
      end
   end

   assign red     = red_ff;
   assign green   = green_ff;
   assign blue    = blue_ff;
   assign inv_sat = inv_sat2_ff;
   assign val     = val2_ff;

endmodule

// File: hdl/hsvrgb_chan.sv
// ----------------------------------------------------------------------------
// hsvrgb_chan
// applies saturation lift and value scaling to one color channel
// ----------------------------------------------------------------------------
module hsvrgb_chan (
   input  logic                     clock,
   input  hsvrgb_pkg::chan_ctl_type ctl,
   input  logic [7:0]               chan_in,
   input  logic [6:0]               inv_sat,
   input  logic [6:0]               val,
   output logic [7:0]               chan_out
);

   logic [14:0] lift_num_ff, lift_num_in;
   logic [7:0]  base_ff;
   logic [6:0]  val3_ff;
   logic [7:0]  lifted_ff, lifted_in;
   logic [6:0]  val4_ff;
   logic [14:0] scale_num_ff, scale_num_in;
   logic [7:0]  out_ff, out_in;

   logic [7:0]  head;
   logic [8:0]  lift_sum;

   // stage 3: headroom times inverse saturation
   always_comb begin
      head        = hsvrgb_pkg::FULL_SCALE - chan_in;
      lift_num_in = 15'(head) * 15'(inv_sat);
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_lift_mul) begin
         lift_num_ff <= lift_num_in;
         base_ff     <= chan_in;
         val3_ff     <= val;
      end
   end

   // stage 4: lift toward full scale, never exceeds 255
   always_comb begin
      lift_sum  = {1'b0, base_ff} + {1'b0, hsvrgb_pkg::div100(lift_num_ff)};
      lifted_in = lift_sum[7:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_lift_add) begin
         lifted_ff <= lifted_in;
         val4_ff   <= val3_ff;
      end
   end

   // stage 5: value product
   assign scale_num_in = 15'(lifted_ff) * 15'(val4_ff);

   always_ff @(posedge clock) begin
      if (ctl.ld_scale_mul) begin
         scale_num_ff <= scale_num_in;
      end
   end

   // stage 6: divide down to 8 bits
   assign out_in = hsvrgb_pkg::div100(scale_num_ff);

   always_ff @(posedge clock) begin
      if (ctl.ld_out) begin
         out_ff <= out_in;
      end
   end

   assign chan_out = out_ff;

endmodule

// File: hdl/hsv_to_rgb_percent.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_percent
// hsv (whole degrees, percent) to 8-bit rgb conversion pipeline
// throughput: one word per cycle while the output is not stalled, through six register stages in a row
// a stalled stage holds its word; only bubbles ahead of it keep moving
// reset clears the stage valid bits only; data registers are not reset
// ----------------------------------------------------------------------------
module hsv_to_rgb_percent (
   input  logic             clock,
   input  logic             reset,
   hsvrgb_req_if.sink       req_bus,
   hsvrgb_rsp_if.source     rsp_bus
);

   localparam int DEPTH = hsvrgb_pkg::PIPE_DEPTH;

   // one valid bit per stage, index 0 is the clamp stage, last is the output
   logic [DEPTH-1:0] vld_ff, vld_in;
   // stage load enables, a stage loads when empty or when its successor moves
   logic [DEPTH-1:0] ld;

   hsvrgb_pkg::sec_ctl_type  sec_ctl;
   hsvrgb_pkg::chan_ctl_type chan_ctl;

   logic [7:0] pure_red, pure_green, pure_blue;
   logic [6:0] inv_sat, val;

   // back-to-front ready chain
   always_comb begin
      ld[DEPTH-1] = !vld_ff[DEPTH-1] || rsp_bus.ready;
      for (int k = DEPTH - 2; k >= 0; k--) begin
         ld[k] = !vld_ff[k] || ld[k+1];
      end
   end

   // valid bits move with their words
   always_comb begin
      vld_in = vld_ff;
      if (ld[0]) begin
         vld_in[0] = req_bus.valid;
      end
      for (int k = 1; k < DEPTH; k++) begin
         if (ld[k]) begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_bus.ready = ld[0];

   // stage loads, gated by the word entering each stage
   always_comb begin
      sec_ctl.ld_clamp      = ld[0] && req_bus.valid;
      sec_ctl.ld_color      = ld[1] && vld_ff[0];
      chan_ctl.ld_lift_mul  = ld[2] && vld_ff[1];
      chan_ctl.ld_lift_add  = ld[3] && vld_ff[2];
      chan_ctl.ld_scale_mul = ld[4] && vld_ff[3];
      chan_ctl.ld_out       = ld[5] && vld_ff[4];
   end

   // stages 1-2: clamp, sector and pure hue color
   hsvrgb_sector u_sector (
      .clock      (clock),
      .ctl        (sec_ctl),
      .hue        (req_bus.hue),
      .saturation (req_bus.saturation),
      .brightness (req_bus.brightness),
      .red        (pure_red),
      .green      (pure_green),
      .blue       (pure_blue),
      .inv_sat    (inv_sat),
      .val        (val)
   );

   // stages 3-6: saturation and value, one lane per channel
   hsvrgb_chan u_chan_red (
      .clock    (clock),
      .ctl      (chan_ctl),
      .chan_in  (pure_red),
      .inv_sat  (inv_sat),
      .val      (val),
      .chan_out (rsp_bus.red)
   );

   hsvrgb_chan u_chan_green (
      .clock    (clock),
      .ctl      (chan_ctl),
      .chan_in  (pure_green),
      .inv_sat  (inv_sat),
      .val      (val),
      .chan_out (rsp_bus.green)
   );

   hsvrgb_chan u_chan_blue (
      .clock    (clock),
      .ctl      (chan_ctl),
      .chan_in  (pure_blue),
      .inv_sat  (inv_sat),
      .val      (val),
      .chan_out (rsp_bus.blue)
   );

   assign rsp_bus.valid = vld_ff[DEPTH-1];

`ifndef SYNTHESIS
   // pipe is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("response valid after reset");

   // a free output slot always frees the input
   a_free_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.ready || !rsp_bus.valid) |-> req_bus.ready)
      else $error("input stalled while output moves");

   // full pipe with a stalled output must hold off the input
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((&vld_ff) && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("input accepted into a full stalled pipe");

   // an accepted word lands in the first stage
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> vld_ff[0])
      else $error("accepted word lost at the first stage");
`endif

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the hsv to rgb pipe: request words go in through a random-gap
// driver, response words come out through a random-stall monitor, and each
// response is compared field by field with an rgb value predicted on accept
// ----------------------------------------------------------------------------
module tb;

   localparam int RANDOM_WORDS = 1880;
   localparam int TAIL_WORDS   = 200;      // last words go through with no idling
   localparam int HOLD_AFTER   = 600;      // words sent before the long receiver hold
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = hsvrgb_pkg::PIPE_DEPTH + 10;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic [8:0] hue;
      logic [6:0] saturation;
      logic [6:0] brightness;
   } hsv_word_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_word_type;

   logic clock;
   logic reset;

   hsvrgb_req_if req_bus ();
   hsvrgb_rsp_if rsp_bus ();

   hsv_to_rgb_percent uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // request words waiting to be offered, and rgb values waiting to come out
   hsv_word_type pending_hsv[$];
   rgb_word_type rgb_expected[$];

   int           fail_count  = 0;
   int           words_sent  = 0;
   int           cycle_count = 0;
   int           gap_left    = 0;
   int           stall_left  = 0;
   int           hold_left   = 0;
   logic         hold_done   = 1'b0;
   logic         calm        = 1'b0;
   logic         send_idle_en = 1'b1;
   logic         recv_idle_en = 1'b1;
   hsv_word_type next_hsv;
   rgb_word_type want_rgb;

   // 4 ns clock
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // color predictor
   // ------------------------------------------------------------------------

   // hue picks a sector and a ramp offset, saturation lifts each channel
   // toward full scale, brightness scales it down; every divide truncates
   function automatic rgb_word_type predict_rgb(hsv_word_type w);
      int unsigned            hue_d;
      int unsigned            inv_sat;
      int unsigned            val;
      int unsigned            off;
      int unsigned            ramp;
      int unsigned            full;
      int unsigned            pct;
      int unsigned            chan[3];
      hsvrgb_pkg::sector_type sec;
      rgb_word_type           res;
      full = 32'(hsvrgb_pkg::FULL_SCALE);
      pct  = 32'(hsvrgb_pkg::PCT_MAX);
      // out-of-range inputs saturate
      hue_d   = (w.hue > hsvrgb_pkg::HUE_MAX) ? 32'(hsvrgb_pkg::HUE_MAX) : 32'(w.hue);
      inv_sat = pct - ((w.saturation > hsvrgb_pkg::PCT_MAX) ? pct : 32'(w.saturation));
      val     = (w.brightness > hsvrgb_pkg::PCT_MAX) ? pct : 32'(w.brightness);
      // sector bounds are inclusive at the top: 60 is still the first one
      if (hue_d < 32'(hsvrgb_pkg::SEC1_START)) begin
         sec = hsvrgb_pkg::SEC_RED_UP;     off = hue_d;
      end else if (hue_d < 32'(hsvrgb_pkg::SEC2_START)) begin
         sec = hsvrgb_pkg::SEC_GREEN_DOWN; off = hue_d - 32'(hsvrgb_pkg::SEC1_BASE);
      end else if (hue_d < 32'(hsvrgb_pkg::SEC3_START)) begin
         sec = hsvrgb_pkg::SEC_BLUE_UP;    off = hue_d - 32'(hsvrgb_pkg::SEC2_BASE);
      end else if (hue_d < 32'(hsvrgb_pkg::SEC4_START)) begin
         sec = hsvrgb_pkg::SEC_GREEN_DN2;  off = hue_d - 32'(hsvrgb_pkg::SEC3_BASE);
      end else if (hue_d < 32'(hsvrgb_pkg::SEC5_START)) begin
         sec = hsvrgb_pkg::SEC_RED_UP2;    off = hue_d - 32'(hsvrgb_pkg::SEC4_BASE);
      end else begin
         sec = hsvrgb_pkg::SEC_BLUE_DOWN;  off = hue_d - 32'(hsvrgb_pkg::SEC5_BASE);
      end
      ramp = (32'(hsvrgb_pkg::RAMP_SLOPE) * off) / pct;
      // channel order: red, green, blue
      case (sec)
         hsvrgb_pkg::SEC_RED_UP:     chan = '{full, ramp, 0};
         hsvrgb_pkg::SEC_GREEN_DOWN: chan = '{full - ramp, full, 0};
         hsvrgb_pkg::SEC_BLUE_UP:    chan = '{0, full, ramp};
         hsvrgb_pkg::SEC_GREEN_DN2:  chan = '{0, full - ramp, full};
         hsvrgb_pkg::SEC_RED_UP2:    chan = '{ramp, 0, full};
         default:                    chan = '{full, 0, full - ramp};
      endcase
      foreach (chan[i]) begin
         chan[i] = chan[i] + ((full - chan[i]) * inv_sat) / pct;
         chan[i] = (chan[i] * val) / pct;
      end
      res.red   = chan[0][7:0];
      res.green = chan[1][7:0];
      res.blue  = chan[2][7:0];
      return res;
   endfunction

   function automatic hsv_word_type hsv(int unsigned h, int unsigned s, int unsigned v);
      hsv_word_type w;
      w.hue        = h[8:0];
      w.saturation = s[6:0];
      w.brightness = v[6:0];
      return w;
   endfunction

   task automatic check_channel(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // ------------------------------------------------------------------------
   // stimulus, reset and end of run
   // ------------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.hue        = '0;
      req_bus.saturation = '0;
      req_bus.brightness = '0;
      rsp_bus.ready      = 1'b0;

      // directed: both edges of every sector, hue 360 and beyond,
      // saturation and brightness at zero, full and above full
      pending_hsv.push_back(hsv(0,   100, 100));
      pending_hsv.push_back(hsv(60,  100, 100));
      pending_hsv.push_back(hsv(61,  100, 100));
      pending_hsv.push_back(hsv(120, 100, 100));
      pending_hsv.push_back(hsv(121, 100, 100));
      pending_hsv.push_back(hsv(180, 100, 100));
      pending_hsv.push_back(hsv(181, 100, 100));
      pending_hsv.push_back(hsv(240, 100, 100));
      pending_hsv.push_back(hsv(241, 100, 100));
      pending_hsv.push_back(hsv(300, 100, 100));
      pending_hsv.push_back(hsv(301, 100, 100));
      pending_hsv.push_back(hsv(359, 100, 100));
      pending_hsv.push_back(hsv(360, 100, 100));   // wraps to pure red
      pending_hsv.push_back(hsv(361, 100, 100));
      pending_hsv.push_back(hsv(511, 127, 127));   // all fields at their top code
      pending_hsv.push_back(hsv(30,  0,   100));   // no saturation gives white
      pending_hsv.push_back(hsv(200, 0,   0));
      pending_hsv.push_back(hsv(90,  101, 50));
      pending_hsv.push_back(hsv(150, 50,  101));
      pending_hsv.push_back(hsv(270, 127, 0));
      pending_hsv.push_back(hsv(45,  37,  73));
      pending_hsv.push_back(hsv(330, 100, 1));
      pending_hsv.push_back(hsv(0,   0,   127));

      // random: mostly legal ranges, some words past the saturation points
      repeat (RANDOM_WORDS) begin
         next_hsv.hue        = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(361, 511))
                                                           : 9'($urandom_range(0, 360));
         next_hsv.saturation = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(101, 127))
                                                           : 7'($urandom_range(0, 100));
         next_hsv.brightness = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(101, 127))
                                                           : 7'($urandom_range(0, 100));
         pending_hsv.push_back(next_hsv);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // every word offered and taken
      while (pending_hsv.size() != 0 || req_bus.valid) @(posedge clock);
      // every response back, then a few more cycles to catch strays
      while (rgb_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // driver: offers request words from the pending queue with random gaps
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left      <= 0;
         calm          <= 1'b0;
      end else begin
         calm <= (pending_hsv.size() <= TAIL_WORDS);
         // idling switches on and off now and then for quiet stretches
         if ($urandom_range(0, 99) == 0) begin
            send_idle_en <= !send_idle_en;
         end
         if (req_bus.valid && !req_bus.ready) begin
            // word not taken yet, keep it on the bus
         end else if (gap_left != 0) begin
            req_bus.valid <= 1'b0;
            gap_left      <= gap_left - 1;
         end else if (send_idle_en && !calm && $urandom_range(0, 5) == 0) begin
            // burst of idle cycles of random length, this one included
            req_bus.valid <= 1'b0;
            gap_left      <= int'($urandom_range(0, 17));
         end else if (pending_hsv.size() != 0) begin
            next_hsv = pending_hsv.pop_front();
            req_bus.valid      <= 1'b1;
            req_bus.hue        <= next_hsv.hue;
            req_bus.saturation <= next_hsv.saturation;
            req_bus.brightness <= next_hsv.brightness;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // long receiver hold once the pipe is busy, so that it backs up into the input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && words_sent >= HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ------------------------------------------------------------------------
   // monitor: checks response words, records request words, drives ready
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
      end else begin
         // response first: it can never belong to a word taken at this edge
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (rgb_expected.size() == 0) begin
               $error("response word with no request outstanding: r=%0d g=%0d b=%0d",
                      rsp_bus.red, rsp_bus.green, rsp_bus.blue);
               fail_count++;
            end else begin
               want_rgb = rgb_expected.pop_front();
               check_channel("red",   want_rgb.red,   rsp_bus.red);
               check_channel("green", want_rgb.green, rsp_bus.green);
               check_channel("blue",  want_rgb.blue,  rsp_bus.blue);
            end
         end

         if (req_bus.valid && req_bus.ready) begin
            rgb_expected.push_back(predict_rgb(hsv(32'(req_bus.hue),
                                                   32'(req_bus.saturation),
                                                   32'(req_bus.brightness))));
            words_sent <= words_sent + 1;
         end

         if ($urandom_range(0, 99) == 0) begin
            recv_idle_en <= !recv_idle_en;
         end

         // ready: long hold, then stall bursts, otherwise open
         if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left != 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= stall_left - 1;
         end else if (recv_idle_en && !calm && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= int'($urandom_range(0, 17));
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

endmodule

// File: files.f
hdl/hsvrgb_pkg.sv
hdl/hsvrgb_if.sv
hdl/hsvrgb_sector.sv
hdl/hsvrgb_chan.sv
hdl/hsv_to_rgb_percent.sv
sim/tb.sv
